### src/assert_macros.svh
// Assertion macros used by the checker file of the RBF kernel unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RBFK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbfk assertion failed");

// Next-cycle implication, off while reset is high.
`define RBFK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbfk assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define RBFK_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbfk assertion failed");

`endif

### src/rbfk_pkg.sv
// Shared types and constants of the RBF kernel unit.
// No dependencies; imported by the front, queue, back and top modules.
package rbfk_pkg;

  localparam int SUM_W       = 40;
  localparam int ELEM_W      = 16;
  localparam int SQ_W        = 32;
  localparam int GAMMA_W     = 24;
  localparam int KV_W        = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd32768;
  // log2(e) in Q1.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  // exponent cut-off: gamma*sum >= 12.0 in Q.32 gives zero
  localparam logic [63:0] EXP_LIMIT = 64'h0000_000C_0000_0000;

  // finished squared-distance sum of one vector pair
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             overflow;
  } rbfk_pair_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_ADD,
    BK_ROUND,
    BK_LOG_MUL,
    BK_LOG_RND,
    BK_RD_LO,
    BK_RD_HI,
    BK_DIFF,
    BK_DMUL,
    BK_INTERP,
    BK_SHIFT,
    BK_OUT
  } rbfk_state_t;

endpackage

### src/rbf_kernel_value_unit.sv
// Gaussian RBF kernel entry exp(-gamma*||x-y||^2) from a stream of coordinate words.
// Throughput: one coordinate word per cycle while full is low; the exponential unit
// works on one pair at a time, taking pairs from the queue into the result register.
// A two-entry pair queue lets short pairs run ahead of the exponential unit.
// Reset (rst, synchronous, active high): sum and overflow flag clear, queue and
// result register empty, gamma_scale back to 0.5 (Q8.16).
module rbf_kernel_value_unit #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // input words
  input  logic                               push,
  output logic                               full,
  input  logic signed [rbfk_pkg::ELEM_W-1:0] x_element,
  input  logic signed [rbfk_pkg::ELEM_W-1:0] y_element,
  input  logic                               last_element,
  // result words
  output logic                               empty,
  input  logic                               pop,
  output logic [rbfk_pkg::KV_W-1:0]          kernel_value,
  output logic                               sum_saturated,
  // gamma_scale register, Q8.16
  input  logic                               cfg_wr_en,
  input  logic [rbfk_pkg::GAMMA_W-1:0]       cfg_wr_data
);
  import rbfk_pkg::*;

  logic [GAMMA_W-1:0] gamma_scale;
  logic               q_push;
  rbfk_pair_t         q_wdata;
  logic               q_full;
  logic               q_pop;
  rbfk_pair_t         q_rdata;
  logic               q_empty;

  // Software must write gamma only while no pair is in flight; the block itself
  // does not enforce this. The back end reads it directly without a shadow copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_scale <= GAMMA_RESET;
    end else if (cfg_wr_en) begin
      gamma_scale <= cfg_wr_data;
    end
  end

  // Front: subtract, square (one 16x16 multiplier) and accumulate into a
  // saturating 40-bit Q24.16 sum. On a last word, push the finished sum and
  // its overflow flag to the queue and clear the accumulator.
  rbfk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .x_element    (x_element),
    .y_element    (y_element),
    .last_element (last_element),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  // Pair queue: decouples the per-word front from the per-pair back.
  rbfk_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  // Back: gamma*sum in two 24x20 partial products, round to Q.16, scale by
  // log2(e), then split into integer shift and table fraction. The fraction
  // table is read twice (entry and neighbor) for linear interpolation, and
  // the shift and saturation produce the Q0.16 result word.
  rbfk_back #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .gamma_scale   (gamma_scale),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .kernel_value  (kernel_value),
    .sum_saturated (sum_saturated)
  );

endmodule

### src/rbfk_front.sv
// Front end: accepts coordinate words, squares differences, accumulates per pair.
// Depends on rbfk_pkg; feeds rbfk_queue.
module rbfk_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [rbfk_pkg::ELEM_W-1:0] x_element,
  input  logic signed [rbfk_pkg::ELEM_W-1:0] y_element,
  input  logic                              last_element,
  output logic                              q_push,
  output rbfk_pkg::rbfk_pair_t              q_data,
  input  logic                              q_full
);
  import rbfk_pkg::*;

  logic [ELEM_W:0]  diff;
  logic [ELEM_W:0]  mag;
  logic [SQ_W-1:0]  in_sq;
  logic             s1_valid;
  logic [SQ_W-1:0]  s1_sq;
  logic             s1_last;
  logic [SUM_W-1:0] acc;
  logic             ovf;
  logic [SUM_W:0]   acc_sum;
  logic [SUM_W-1:0] sum_next;
  logic             ovf_next;
  logic             stall;
  logic             advance;
  logic             accept;

  always_comb begin
    diff  = {x_element[ELEM_W-1], x_element} - {y_element[ELEM_W-1], y_element};
    mag   = diff[ELEM_W] ? ((ELEM_W+1)'(0) - diff) : diff;
    in_sq = {16'd0, mag[ELEM_W-1:0]} * {16'd0, mag[ELEM_W-1:0]};
  end

  // hold a last word while the queue has no room
  assign stall   = s1_valid & s1_last & q_full;
  assign advance = s1_valid & ~stall;
  assign full    = stall;
  assign accept  = push & ~stall;

  always_comb begin
    acc_sum  = {1'b0, acc} + {(SUM_W+1-SQ_W)'(0), s1_sq};
    sum_next = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
    ovf_next = ovf | acc_sum[SUM_W];
    q_push   = advance & s1_last;
    q_data   = '{sum: sum_next, overflow: ovf_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
      ovf      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        if (s1_last) begin
          acc <= '0;
          ovf <= 1'b0;
        end else begin
          acc <= sum_next;
          ovf <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq   <= in_sq;
      s1_last <= last_element;
    end
  end

endmodule

### src/rbfk_queue.sv
// Short queue of finished pair sums between front and back.
// Depends on rbfk_pkg.
module rbfk_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_push,
  input  rbfk_pkg::rbfk_pair_t q_wdata,
  output logic                 q_full,
  input  logic                 q_pop,
  output rbfk_pkg::rbfk_pair_t q_rdata,
  output logic                 q_empty
);
  import rbfk_pkg::*;

  rbfk_pair_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign q_full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_push = q_push & ~q_full;
  assign do_pop  = q_pop & ~q_empty;
  assign q_rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_wdata;
    end
  end

endmodule

### src/rbfk_back.sv
// Back end: evaluates exp(-gamma*sum) for one pair sum over a fixed sequence.
// Depends on rbfk_pkg; drains rbfk_queue and drives the result register.
module rbfk_back #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rbfk_pkg::GAMMA_W-1:0]      gamma_scale,
  input  rbfk_pkg::rbfk_pair_t              q_rdata,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic [rbfk_pkg::KV_W-1:0]         kernel_value,
  output logic                              sum_saturated
);
  import rbfk_pkg::*;

  localparam int TABLE_SIZE = (1 << EXP_TABLE_BITS) + 1;
  localparam int S          = 16 - EXP_TABLE_BITS;
  localparam int DM_W       = 33 + S;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    int          i;
    v    = v_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bitv > v) begin
        bitv = bitv >> 2;
      end
    end
    for (i = 0; i < 32; i++) begin
      if (bitv != 64'd0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // 2^(-idx/2^EXP_TABLE_BITS) in Q1.32 from products of repeated square roots of 0.5
  function automatic logic [32:0] frac_entry(input int idx);
    logic [63:0] roots [EXP_TABLE_BITS+1];
    logic [65:0] p;
    int          k;
    int          j;
    roots[0] = 64'd1 << 31;
    for (k = 1; k <= EXP_TABLE_BITS; k++) begin
      roots[k] = isqrt64(roots[k-1] << 32);
    end
    if (idx == TABLE_SIZE - 1) begin
      return 33'd1 << 31;
    end
    p = 66'd1 << 32;
    for (j = 0; j < EXP_TABLE_BITS; j++) begin
      if (((idx >> j) & 1) != 0) begin
        p = (p * {2'b00, roots[EXP_TABLE_BITS-j]} + (66'd1 << 31)) >> 32;
      end
    end
    return p[32:0];
  endfunction

  logic [32:0] frac_rom [TABLE_SIZE];

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
    assign frac_rom[g] = frac_entry(g);
  end

  rbfk_state_t state;
  rbfk_state_t state_next;

  logic [SUM_W-1:0]        sum_r;
  logic                    ovf_r;
  logic [43:0]             p_lo;
  logic [43:0]             p_hi;
  logic [63:0]             prod;
  logic                    big;
  logic [19:0]             t16;
  logic [50:0]             lm;
  logic [20:0]             u;
  logic [EXP_TABLE_BITS:0] rom_addr;
  logic [32:0]             rom_data;
  logic [32:0]             tab_lo;
  logic [32:0]             tab_diff;
  logic [DM_W-1:0]         dm;
  logic [32:0]             val;
  logic [34:0]             sh;
  logic                    out_valid;
  logic                    out_load;
  logic [KV_W-1:0]         kv_c;

  logic [36:0]               rnd;
  logic [50:0]               lm_rnd;
  logic [4:0]                n;
  logic [EXP_TABLE_BITS-1:0] idx;
  logic [S-1:0]              rem;
  logic [DM_W-1:0]           dm_rnd;
  logic [34:0]               sh_sum;
  logic [5:0]                n6;

  always_comb begin
    rnd    = {1'b0, prod[35:0]} + 37'h0_0000_8000;
    lm_rnd = lm + (51'd1 << 29);
    n      = u[20:16];
    n6     = {1'b0, n};
    idx    = u[15:S];
    rem    = u[S-1:0];
    dm_rnd = dm + (DM_W'(1) << (S - 1));
    sh_sum = {2'b00, val} + (35'd1 << (6'd15 + n6));
    kv_c   = big ? '0 : ((|sh[34:16]) ? {KV_W{1'b1}} : sh[15:0]);
  end

  // second table read fetches the upper neighbor
  assign rom_addr = (state == BK_RD_HI) ? ({1'b0, idx} + 1'b1) : {1'b0, idx};

  always_ff @(posedge clk) begin
    rom_data <= frac_rom[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_MUL_LO;
        end
      end
      BK_MUL_LO:  state_next = BK_MUL_HI;
      BK_MUL_HI:  state_next = BK_ADD;
      BK_ADD:     state_next = BK_ROUND;
      BK_ROUND:   state_next = BK_LOG_MUL;
      BK_LOG_MUL: state_next = BK_LOG_RND;
      BK_LOG_RND: state_next = BK_RD_LO;
      BK_RD_LO:   state_next = BK_RD_HI;
      BK_RD_HI:   state_next = BK_DIFF;
      BK_DIFF:    state_next = BK_DMUL;
      BK_DMUL:    state_next = BK_INTERP;
      BK_INTERP:  state_next = BK_SHIFT;
      BK_SHIFT:   state_next = BK_OUT;
      BK_OUT: begin
        // wait for the result register to free up
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default:    state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        sum_r <= q_rdata.sum;
        ovf_r <= q_rdata.overflow;
      end
      BK_MUL_LO:  p_lo <= {20'd0, gamma_scale} * {24'd0, sum_r[19:0]};
      BK_MUL_HI:  p_hi <= {20'd0, gamma_scale} * {24'd0, sum_r[39:20]};
      BK_ADD:     prod <= {20'd0, p_lo} + {p_hi, 20'd0};
      BK_ROUND: begin
        big <= (prod >= EXP_LIMIT);
        t16 <= rnd[35:16];
      end
      BK_LOG_MUL: lm <= {31'd0, t16} * {20'd0, LOG2E_Q30};
      BK_LOG_RND: u <= lm_rnd[50:30];
      BK_RD_HI:   tab_lo <= rom_data;
      BK_DIFF:    tab_diff <= tab_lo - rom_data;
      BK_DMUL:    dm <= DM_W'(tab_diff) * DM_W'(rem);
      BK_INTERP:  val <= tab_lo - 33'(dm_rnd >> S);
      BK_SHIFT:   sh <= sh_sum >> (6'd16 + n6);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kernel_value  <= kv_c;
      sum_saturated <= ovf_r;
    end
  end

  assign empty = ~out_valid;

endmodule

### src/rbfk_checker.sv
// Port-level checks of the RBF kernel unit, bound to the top level.
// Depends on assert_macros.svh and rbf_kernel_value_unit.
`include "assert_macros.svh"

module rbfk_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        last_element,
  input logic        empty,
  input logic        pop,
  input logic [15:0] kernel_value,
  input logic        sum_saturated
);

  // reset leaves no result waiting and the input open
  `RBFK_ASSERT_RST(a_reset_idle, clk, rst, empty && !full)

  // an unaccepted result word holds
  `RBFK_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(kernel_value) && $stable(sum_saturated))

  // input backpressure only starts right after a last word went in
  `RBFK_ASSERT_IMP(a_full_after_last, clk, rst, $rose(full), $past(push && !full && last_element))

endmodule

bind rbf_kernel_value_unit rbfk_checker u_rbfk_checker (.*);
